// ===== rtl/core/bfc_pkg.sv =====
// Shared types and constants of the bitmap font text console.
package bfc_pkg;

  localparam int EMIT_ROWS    = 16;
  localparam int ROW_CNT_W    = $clog2(EMIT_ROWS);
  localparam int GLYPH_WIDTH  = 8;
  localparam int LINE_STEP    = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PRINT = 1'b1;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_NEWLINE = 2'd1;
  localparam logic [1:0] CMD_PRINT   = 2'd2;

  localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] CFG_ROW_PITCH   = 2'd1;
  localparam logic [1:0] CFG_FRAME_BASE  = 2'd2;
  localparam logic [1:0] CFG_FG_COLOR    = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [3:0] row;
    logic [7:0] bits;
  } cmd_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [13:0] row_pitch;
    logic [63:0] frame_base;
    logic [31:0] fg_color;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 emitting;
    logic [ROW_CNT_W-1:0] row_cnt;
  } back_status_t;

endpackage

// ===== rtl/core/bfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bfc_front.sv =====
// Front end: accepts requests, classifies them and drops ignored glyph loads.
module bfc_front #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [7:0]    in_char_code,
  input  logic [3:0]    in_glyph_row,
  input  logic [7:0]    in_glyph_bits,
  input  logic          q_full,
  output logic          q_push,
  output bfc_pkg::cmd_t q_cmd
);
  import bfc_pkg::*;

  logic load_ok;

  always_comb begin
    load_ok = ({2'b0, in_glyph_row} < 6'(GLYPH_ROWS)) &&
              ({2'b0, in_char_code} < 10'(GLYPH_COUNT));
    q_cmd.code = in_char_code;
    q_cmd.row  = in_glyph_row;
    q_cmd.bits = in_glyph_bits;
    if (in_action == ACT_LOAD) begin
      q_cmd.kind = CMD_LOAD;
    end else if (in_char_code == NEWLINE_CODE) begin
      q_cmd.kind = CMD_NEWLINE;
    end else begin
      q_cmd.kind = CMD_PRINT;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && ((in_action == ACT_PRINT) || load_ok);

endmodule

// ===== rtl/core/bfc_queue.sv =====
// Short command queue between front end and back end.
module bfc_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  bfc_pkg::cmd_t             push_cmd,
  output logic                      full,
  input  logic                      pop,
  output logic                      head_valid,
  output bfc_pkg::cmd_t             head_cmd,
  output logic [bfc_pkg::QCNT_W-1:0] count
);
  import bfc_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/bfc_back.sv =====
// Back end: glyph loads, cursor moves and row emission with output register.
module bfc_back #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfc_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  bfc_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_row_address,
  output logic [7:0]            out_row_mask,
  output logic [31:0]           out_paint_color,
  output logic                  out_last_row,
  output bfc_pkg::back_status_t status
);
  import bfc_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [30:0]          pix_r, pix_nxt;
  logic [63:0]          addr_r, addr_nxt;
  logic [ROW_CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [12:0]          cur_x_r, cur_x_nxt;
  logic [15:0]          cur_y_r, cur_y_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [63:0]          s1_addr_r;
  logic                 s1_last_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          out_addr_r;
  logic [7:0]           out_mask_r;
  logic                 out_last_r;

  logic                 out_load, s1_adv, issue;
  logic                 ram_we;
  logic [IDX_W-1:0]     load_idx, print_base;
  logic [9:0]           code_ext, code_mod;
  logic [12:0]          x_step;
  logic [7:0]           ram_rdata;

  always_comb begin
    code_ext   = {2'b0, q_cmd.code};
    code_mod   = (code_ext >= 10'(GLYPH_COUNT)) ? code_ext - 10'(GLYPH_COUNT) : code_ext;
    print_base = IDX_W'(code_mod) * IDX_W'(GLYPH_ROWS);
    load_idx   = IDX_W'(q_cmd.code) * IDX_W'(GLYPH_ROWS) + IDX_W'(q_cmd.row);
    x_step     = cur_x_r + 13'(GLYPH_WIDTH);
  end

  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign issue    = (state_r == ST_EMIT) && (!s1_valid_r || s1_adv);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pix_nxt     = pix_r;
    addr_nxt    = addr_r;
    row_cnt_nxt = row_cnt_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              ram_we = 1'b1;
            end
            CMD_NEWLINE: begin
              cur_x_nxt = '0;
              cur_y_nxt = cur_y_r + 16'(LINE_STEP);
            end
            CMD_PRINT: begin
              idx_nxt   = print_base;
              state_nxt = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        pix_nxt   = 31'(cur_y_r) * 31'(cfg.row_pitch) + 31'(cur_x_r);
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        addr_nxt    = cfg.frame_base + {31'b0, pix_r, 2'b00};
        row_cnt_nxt = '0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (issue) begin
          addr_nxt    = addr_r + {48'b0, cfg.row_pitch, 2'b00};
          idx_nxt     = (idx_r == IDX_W'(DEPTH - 1)) ? '0 : idx_r + 1'b1;
          row_cnt_nxt = row_cnt_r + 1'b1;
          if (row_cnt_r == ROW_CNT_W'(EMIT_ROWS - 1)) begin
            state_nxt = ST_IDLE;
            if ({1'b0, x_step} + 14'(GLYPH_WIDTH) > {1'b0, cfg.frame_width}) begin
              cur_x_nxt = '0;
              cur_y_nxt = cur_y_r + 16'(LINE_STEP);
            end else begin
              cur_x_nxt = x_step;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pix_r  <= pix_nxt;
    addr_r <= addr_nxt;
    if (issue) begin
      s1_addr_r <= addr_r;
      s1_last_r <= (row_cnt_r == ROW_CNT_W'(EMIT_ROWS - 1));
    end
    if (s1_adv) begin
      out_addr_r <= s1_addr_r;
      out_mask_r <= ram_rdata;
      out_last_r <= s1_last_r;
    end
  end

  bfc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_idx),
    .wdata (q_cmd.bits),
    .re    (issue),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_row_address = out_addr_r;
  assign out_row_mask    = out_mask_r;
  assign out_paint_color = cfg.fg_color;
  assign out_last_row    = out_last_r;

  assign status.start    = q_pop && (q_cmd.kind == CMD_PRINT);
  assign status.emitting = (state_r == ST_EMIT);
  assign status.row_cnt  = row_cnt_r;

endmodule

// ===== rtl/core/bitmap_font_text_console_core.sv =====
// Top level of the bitmap font text console: config registers, front, queue, back.
// A load request or a newline is carried out when the back end fetches it. A printed
// character goes through the command fetch, the y * pitch multiply and the base address
// add, then sixteen rows issue one per cycle from the glyph RAM read port while the
// read stage can advance, each row address stepped by 4 * pitch. Results pass through a
// read stage and an output register, so rows stream at one per cycle when the
// consumer is ready. The two-entry command queue takes new requests while the
// back end works. The glyph RAM holds GLYPH_COUNT * GLYPH_ROWS bytes and is not
// cleared; printing a glyph row that was never loaded gives an undefined mask.
module bitmap_font_text_console_core #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_glyph_row,
  input  logic [7:0]  in_glyph_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row_address,
  output logic [7:0]  out_row_mask,
  output logic [31:0] out_paint_color,
  output logic        out_last_row
);
  import bfc_pkg::*;

  cfg_t              cfg_r;
  cmd_t              front_cmd, head_cmd;
  logic              q_full, q_push, q_pop, head_valid;
  logic [QCNT_W-1:0] q_count;
  back_status_t      back_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width <= 13'd640;
      cfg_r.row_pitch   <= 14'd640;
      cfg_r.frame_base  <= '0;
      cfg_r.fg_color    <= 32'hffff_ffff;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: cfg_r.frame_width <= cfg_wdata[12:0];
        CFG_ROW_PITCH:   cfg_r.row_pitch   <= cfg_wdata[13:0];
        CFG_FRAME_BASE:  cfg_r.frame_base  <= cfg_wdata;
        CFG_FG_COLOR:    cfg_r.fg_color    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  bfc_front #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_glyph_row  (in_glyph_row),
    .in_glyph_bits (in_glyph_bits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (front_cmd)
  );

  bfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .count      (q_count)
  );

  bfc_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (head_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_address (out_row_address),
    .out_row_mask    (out_row_mask),
    .out_paint_color (out_paint_color),
    .out_last_row    (out_last_row),
    .status          (back_status)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_row_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !back_status.emitting |-> back_status.row_cnt == '0)
    else $error("row counter not cleared outside emission");

  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    back_status.start |=> !back_status.emitting && !q_pop)
    else $error("print started without address setup");
`endif

endmodule
